// File: src/assert_macros.svh
// Assertion macros, included by the top-level tracker module.
// Both forms sample on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define LST_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define LST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Types and constants shared by the lane scan line tracker modules.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = COL_W + 1;
    localparam int ROW_W     = 10;
    localparam int PIX_W     = 8;
    localparam int THR_W     = 8;
    localparam int TOL_W     = 11;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(48);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(5);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    // stream word layout
    localparam int S_TDATA_W = ((PIX_W + ROW_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((ROW_W + 3 * COL_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_TOLERANCE = 2'd1,
        CFG_ROW_WIDTH = 2'd2
    } t_cfg_idx;

    // row queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // one finished row, as handed from the scanner to the tracker
    typedef struct packed {
        logic             new_frame;
        logic [ROW_W-1:0] lane_row;
        logic             left_ok;
        logic [COL_W-1:0] left_bright;
        logic [COL_W-1:0] left_dark;
        logic             right_ok;
        logic [COL_W-1:0] right_start;
        logic [COL_W-1:0] right_end;
    } t_row_rec;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_CW-1:0] count;
    } t_q_stat;

endpackage

// File: src/lst_front.sv
// ----------------------------------------------------------------------------
// lst_front
// Pixel scanner: tracks the nearest bright runs left and right of center and
// pushes one record per finished row into the row queue.
// ----------------------------------------------------------------------------
module lst_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lst_pkg::PIX_W-1:0]     i_pixel,
    input  logic [lst_pkg::ROW_W-1:0]     i_row_number,
    input  logic                          i_frame_start,
    input  logic [lst_pkg::THR_W-1:0]     i_threshold,
    input  logic [lst_pkg::WIDTH_W-1:0]   i_row_width,
    input  lst_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output lst_pkg::t_row_rec             o_rec
);
    import lst_pkg::*;

    logic [COL_W-1:0] r_col,   n_col;
    logic             r_nf,    n_nf;
    logic [COL_W-1:0] r_lb,    n_lb;
    logic             r_lb_v,  n_lb_v;
    logic [COL_W-1:0] r_ldb,   n_ldb;
    logic             r_ldb_v, n_ldb_v;
    logic [COL_W-1:0] r_ld,    n_ld;
    logic             r_ld_v,  n_ld_v;
    logic [COL_W-1:0] r_rs,    n_rs;
    logic             r_rs_v,  n_rs_v;
    logic [COL_W-1:0] r_re,    n_re;
    logic             r_re_v,  n_re_v;

    logic [WIDTH_W-1:0] w_width;
    logic [COL_W-1:0]   w_center;
    logic               w_accept;

    assign w_width  = (i_row_width < WIDTH_MIN) ? WIDTH_MIN :
                      (i_row_width > WIDTH_MAX) ? WIDTH_MAX : i_row_width;
    assign w_center = w_width[WIDTH_W-1:1];
    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        logic [COL_W-1:0] c;
        logic             bright;
        logic             row_end;

        n_col = r_col;   n_nf = r_nf;
        n_lb  = r_lb;    n_lb_v  = r_lb_v;
        n_ldb = r_ldb;   n_ldb_v = r_ldb_v;
        n_ld  = r_ld;    n_ld_v  = r_ld_v;
        n_rs  = r_rs;    n_rs_v  = r_rs_v;
        n_re  = r_re;    n_re_v  = r_re_v;
        c       = '0;
        bright  = 1'b0;
        row_end = 1'b0;
        o_push  = 1'b0;
        o_rec   = '0;

        if (w_accept) begin
            if (i_frame_start) begin
                n_col = '0;
                n_nf  = 1'b1;
                n_lb_v = 1'b0; n_ldb_v = 1'b0; n_ld_v = 1'b0;
                n_rs_v = 1'b0; n_re_v  = 1'b0;
            end
            c      = n_col;
            bright = i_pixel > i_threshold;

            if (c != '0 && c <= w_center) begin
                if (bright) begin
                    n_lb    = c;
                    n_lb_v  = 1'b1;
                    n_ldb   = n_ld;
                    n_ldb_v = n_ld_v;
                end else begin
                    n_ld   = c;
                    n_ld_v = 1'b1;
                end
            end
            if (c >= w_center && {1'b0, c} < w_width) begin
                if (bright) begin
                    if (!n_rs_v) begin
                        n_rs   = c;
                        n_rs_v = 1'b1;
                    end
                end else if (n_rs_v && !n_re_v) begin
                    n_re   = c;
                    n_re_v = 1'b1;
                end
            end

            row_end = !(({1'b0, c} + WIDTH_W'(1)) < w_width);
            if (row_end) begin
                o_push            = 1'b1;
                o_rec.new_frame   = n_nf;
                o_rec.lane_row    = i_row_number;
                o_rec.left_ok     = n_lb_v && n_ldb_v;
                o_rec.left_bright = n_lb;
                o_rec.left_dark   = n_ldb;
                o_rec.right_ok    = n_rs_v && n_re_v;
                o_rec.right_start = n_rs;
                o_rec.right_end   = n_re;
                n_col = '0;
                n_nf  = 1'b0;
                n_lb_v = 1'b0; n_ldb_v = 1'b0; n_ld_v = 1'b0;
                n_rs_v = 1'b0; n_re_v  = 1'b0;
            end else begin
                n_col = c + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_nf    <= 1'b0;
            r_lb_v  <= 1'b0;
            r_ldb_v <= 1'b0;
            r_ld_v  <= 1'b0;
            r_rs_v  <= 1'b0;
            r_re_v  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_nf    <= n_nf;
            r_lb_v  <= n_lb_v;
            r_ldb_v <= n_ldb_v;
            r_ld_v  <= n_ld_v;
            r_rs_v  <= n_rs_v;
            r_re_v  <= n_re_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lb  <= n_lb;
        r_ldb <= n_ldb;
        r_ld  <= n_ld;
        r_rs  <= n_rs;
        r_re  <= n_re;
    end

endmodule

// File: src/lst_queue.sv
// ----------------------------------------------------------------------------
// lst_queue
// Short register queue of finished row records between scanner and tracker.
// ----------------------------------------------------------------------------
module lst_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lst_pkg::t_row_rec i_rec,
    input  logic              i_pop,
    output lst_pkg::t_row_rec o_rec,
    output lst_pkg::t_q_stat  o_stat
);
    import lst_pkg::*;

    t_row_rec        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            w_push;
    logic            w_pop;

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;
    assign o_rec        = r_mem[r_rp];

    always_comb begin
        n_wp  = w_push ? r_wp + Q_AW'(1) : r_wp;
        n_rp  = w_pop  ? r_rp + Q_AW'(1) : r_rp;
        n_cnt = r_cnt + Q_CW'(w_push) - Q_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

// File: src/lst_back.sv
// ----------------------------------------------------------------------------
// lst_back
// Row tracker: turns a row record into marking midpoints and lane center,
// applies the tolerance check against the last accepted pair, and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module lst_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lst_pkg::t_row_rec               i_rec,
    input  lst_pkg::t_q_stat                i_q_stat,
    output logic                            o_pop,
    input  logic [lst_pkg::TOL_W-1:0]       i_tolerance,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lst_pkg::ROW_W-1:0]       o_lane_row,
    output logic [lst_pkg::COL_W-1:0]       o_left_column,
    output logic [lst_pkg::COL_W-1:0]       o_right_column,
    output logic [lst_pkg::COL_W-1:0]       o_center_column,
    output logic                            o_left_found,
    output logic                            o_right_found,
    output logic                            o_accepted
);
    import lst_pkg::*;

    logic             r_valid,  n_valid;
    logic             r_await,  n_await;
    logic [COL_W-1:0] r_last_l, n_last_l;
    logic [COL_W-1:0] r_last_r, n_last_r;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_lc, r_rc, r_cc;
    logic             r_lf, r_rf, r_acc;

    logic [COL_W-1:0] w_lc, w_rc, w_cc;
    logic [COL_W-1:0] w_dl, w_dr;
    logic             w_both, w_await, w_acc;

    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    always_comb begin
        logic [COL_W:0] sum_l;
        logic [COL_W:0] sum_r;
        logic [COL_W:0] sum_c;

        sum_l = {1'b0, i_rec.left_bright} + {1'b0, i_rec.left_dark};
        sum_r = {1'b0, i_rec.right_start} + {1'b0, i_rec.right_end};
        w_lc  = i_rec.left_ok  ? sum_l[COL_W:1] : '0;
        w_rc  = i_rec.right_ok ? sum_r[COL_W:1] : '0;
        w_both = i_rec.left_ok && i_rec.right_ok;
        sum_c = {1'b0, w_lc} + {1'b0, w_rc};
        w_cc  = w_both ? sum_c[COL_W:1] : '0;

        w_dl = (r_last_l > w_lc) ? r_last_l - w_lc : w_lc - r_last_l;
        w_dr = (r_last_r > w_rc) ? r_last_r - w_rc : w_rc - r_last_r;
        w_await = i_rec.new_frame || r_await;
        w_acc = w_both && (w_await ||
                ({1'b0, w_dl} < i_tolerance && {1'b0, w_dr} < i_tolerance));
    end

    always_comb begin
        n_valid  = r_valid;
        n_await  = r_await;
        n_last_l = r_last_l;
        n_last_r = r_last_r;
        if (o_pop) begin
            n_valid = 1'b1;
            if (w_acc) begin
                n_await  = 1'b0;
                n_last_l = w_lc;
                n_last_r = w_rc;
            end else if (i_rec.new_frame) begin
                n_await = 1'b1;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_await  <= 1'b1;
            r_last_l <= '0;
            r_last_r <= '0;
        end else begin
            r_valid  <= n_valid;
            r_await  <= n_await;
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row <= i_rec.lane_row;
            r_lc  <= w_lc;
            r_rc  <= w_rc;
            r_cc  <= w_cc;
            r_lf  <= i_rec.left_ok;
            r_rf  <= i_rec.right_ok;
            r_acc <= w_acc;
        end
    end

    assign o_valid         = r_valid;
    assign o_lane_row      = r_row;
    assign o_left_column   = r_lc;
    assign o_right_column  = r_rc;
    assign o_center_column = r_cc;
    assign o_left_found    = r_lf;
    assign o_right_found   = r_rf;
    assign o_accepted      = r_acc;

endmodule

// File: src/lane_scan_line_tracker.sv
// ----------------------------------------------------------------------------
// lane_scan_line_tracker
// Finds the left and right lane markings around the row center and tracks
// them from row to row.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the queue has room. The scanner updates
// its run registers per pixel and, at the last pixel of a row, writes a row
// record into a 4-deep queue; the tracker pops it into its output register once
// that is free. The input stalls only when four finished rows wait in the queue
// behind a stalled output. The user must write configuration registers through
// the plain write port only while no row is in flight; the block does not check.
module lane_scan_line_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] pixel, [17:8] row_number, rest zero
    input  logic [lst_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] frame_start
    input  logic [lst_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [9:0] lane_row, [19:10] left_column, [29:20] right_column,
    // [39:30] center_column
    output logic [lst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] left_found, [1] right_found, [2] accepted
    output logic [lst_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import lst_pkg::*;

`include "assert_macros.svh"

    logic [THR_W-1:0]   r_thr;
    logic [TOL_W-1:0]   r_tol;
    logic [WIDTH_W-1:0] r_width;

    t_row_rec w_push_rec, w_pop_rec;
    t_q_stat  w_q_stat;
    logic     w_push, w_pop;

    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_lc, w_rc, w_cc;
    logic             w_lf, w_rf, w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_tol   <= TOL_RESET;
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                CFG_TOLERANCE: r_tol   <= i_cfg_data[TOL_W-1:0];
                CFG_ROW_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    lst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata[PIX_W-1:0]),
        .i_row_number  (s_axis_tdata[PIX_W +: ROW_W]),
        .i_frame_start (s_axis_tuser[0]),
        .i_threshold   (r_thr),
        .i_row_width   (r_width),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_rec         (w_push_rec)
    );

    lst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_stat  (w_q_stat)
    );

    lst_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec           (w_pop_rec),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .i_tolerance     (r_tol),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_lane_row      (w_row),
        .o_left_column   (w_lc),
        .o_right_column  (w_rc),
        .o_center_column (w_cc),
        .o_left_found    (w_lf),
        .o_right_found   (w_rf),
        .o_accepted      (w_acc)
    );

    assign m_axis_tdata = M_TDATA_W'({w_cc, w_rc, w_lc, w_row});
    assign m_axis_tuser = {w_acc, w_rf, w_lf};

    `LST_ASSERT(a_q_bound, w_q_stat.count <= Q_CW'(Q_DEPTH), "row queue overflow")
    `LST_ASSERT(a_pop_nonempty, !w_pop || !w_q_stat.empty, "pop from empty row queue")
    `LST_ASSERT(a_push_room, !w_push || !w_q_stat.full, "push into full row queue")
    `LST_ASSERT(a_acc_found,
                !m_axis_tvalid || !w_acc || (w_lf && w_rf),
                "accepted without both markings")
    `LST_ASSERT_NEXT(a_count_step, w_push && !w_pop,
                     w_q_stat.count == $past(w_q_stat.count) + Q_CW'(1),
                     "queue count did not advance")

endmodule

// File: tb/sv/lane_scan_line_tracker_test.sv
// ----------------------------------------------------------------------------
// lane_scan_line_tracker_test
// Self-checking bench for the lane scan line tracker. Pixel words are pushed
// through the input stream while a behavioral tracker in the bench works out
// each row word the table does not give; every row word that leaves the block
// is compared field by field. A short hand-written table opens the run, followed
// by lane-shaped rows with random content and noise over a series of register
// settings, with random input gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module lane_scan_line_tracker_test;
    import lst_pkg::*;

    localparam int N_PHASES       = 12;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 100;
    localparam int IDLE_PAUSE     = 6;
    localparam int DIR_N          = 26;
    localparam logic [WIDTH_W-1:0] NO_COL = WIDTH_W'(MAX_WIDTH);

    typedef struct packed {
        logic [ROW_W-1:0] lane_row;
        logic [COL_W-1:0] left_mid;
        logic [COL_W-1:0] right_mid;
        logic [COL_W-1:0] center_col;
        logic             left_found;
        logic             right_found;
        logic             accepted;
    } t_lane_res;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic             fs;
        logic             typed;
        t_lane_res        res;
    } t_stim;

    localparam t_lane_res NO_RES = '0;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    lane_scan_line_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // tracker state mirrored in the bench
    logic [THR_W-1:0]   cfg_thr;
    logic [TOL_W-1:0]   cfg_tol;
    logic [WIDTH_W-1:0] cfg_width;
    logic [COL_W-1:0]   col_cnt;
    bit                 first_pending;
    logic [COL_W-1:0]   last_left;
    logic [COL_W-1:0]   last_right;
    logic [WIDTH_W-1:0] l_bright;
    logic [WIDTH_W-1:0] l_dark_before;
    logic [WIDTH_W-1:0] l_dark;
    logic [WIDTH_W-1:0] r_start;
    logic [WIDTH_W-1:0] r_end;

    t_lane_res lane_q [$];

    int  n_errors;
    int  n_words;
    int  n_rows;
    int  n_accepted;
    int  n_settings;
    int  burst_left;
    int  lpos;
    int  rpos;
    bit  hold_req;
    bit  hold_done;

    int ph_thr   [N_PHASES] = '{48,    0, 255, 100, 30, 48, 128,  200, 60, 48, 20, 90};
    int ph_tol   [N_PHASES] = '{ 3, 2047,   5,   0,  1,  4,   6, 1024,  2,  8,  5,  3};
    int ph_wid   [N_PHASES] = '{ 8,    6,   5,  10,  1,  0,  16,   20, 12,  3, 11,  7};
    int ph_items [N_PHASES] = '{40,   40,  30,  40, 60, 30,  50,   40, 40, 30, 30, 40};

    // width 4, center column 2
    t_stim dir_tab [0:DIR_N-1] = '{
        // bright center pixel opens both runs, first row after reset
        '{8'd0,   10'd1023, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd1023, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd1023, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd1023, 1'b0, 1'b1,
          '{10'd1023, 10'd1, 10'd2, 10'd1, 1'b1, 1'b1, 1'b1}},
        // left run reaches column 0, no right run
        '{8'd255, 10'd0, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd0, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd0, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd0, 1'b0, 1'b1, NO_RES},
        // pixel at threshold is dark, right run left open
        '{8'd0,   10'd5, 1'b0, 1'b0, NO_RES},
        '{8'd49,  10'd5, 1'b0, 1'b0, NO_RES},
        '{8'd48,  10'd5, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd5, 1'b0, 1'b1, '{10'd5, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0}},
        // same lane again, tracked
        '{8'd0,   10'd6, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd6, 1'b0, 1'b0, NO_RES},
        '{8'd200, 10'd6, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd6, 1'b0, 1'b0, NO_RES},
        // frame restarts mid-row
        '{8'd0,   10'd7, 1'b1, 1'b0, NO_RES},
        '{8'd0,   10'd7, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd7, 1'b1, 1'b0, NO_RES},
        '{8'd0,   10'd7, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd7, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd7, 1'b0, 1'b0, NO_RES},
        // left only
        '{8'd255, 10'd8, 1'b0, 1'b0, NO_RES},
        '{8'd0,   10'd8, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd8, 1'b0, 1'b0, NO_RES},
        '{8'd255, 10'd8, 1'b0, 1'b0, NO_RES}
    };

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int col_dist(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [PIX_W-1:0] dark_pixel();
        return PIX_W'($urandom_range(0, int'(cfg_thr)));
    endfunction

    function automatic logic [PIX_W-1:0] bright_pixel();
        if (cfg_thr == 8'd255) return 8'd255;
        return PIX_W'($urandom_range(int'(cfg_thr) + 1, 255));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_row();
        col_cnt       = '0;
        l_bright      = NO_COL;
        l_dark_before = NO_COL;
        l_dark        = NO_COL;
        r_start       = NO_COL;
        r_end         = NO_COL;
    endtask

    task automatic track_pixel(input logic [PIX_W-1:0] pix, input logic [ROW_W-1:0] rown,
                               input logic fs, output bit got, output t_lane_res res);
        int  w, ctr, c, lc, rc, cc;
        bit  bright, lf, rf, acc;
        w   = eff_width();
        ctr = w / 2;
        got = 1'b0;
        res = NO_RES;
        if (fs) begin
            first_pending = 1'b1;
            restart_row();
        end
        c      = int'(col_cnt);
        bright = pix > cfg_thr;
        if (c >= 1 && c <= ctr) begin
            if (bright) begin
                l_bright      = WIDTH_W'(c);
                l_dark_before = l_dark;
            end else begin
                l_dark = WIDTH_W'(c);
            end
        end
        if (c >= ctr && c < w) begin
            if (bright) begin
                if (r_start == NO_COL) r_start = WIDTH_W'(c);
            end else if (r_start != NO_COL && r_end == NO_COL) begin
                r_end = WIDTH_W'(c);
            end
        end
        if (c + 1 < w) begin
            col_cnt = COL_W'(c + 1);
        end else begin
            lf  = l_bright != NO_COL && l_dark_before != NO_COL;
            rf  = r_start != NO_COL && r_end != NO_COL;
            lc  = lf ? (int'(l_bright) + int'(l_dark_before)) / 2 : 0;
            rc  = rf ? (int'(r_start) + int'(r_end)) / 2 : 0;
            cc  = (lf && rf) ? (lc + rc) / 2 : 0;
            acc = 1'b0;
            if (lf && rf) begin
                if (first_pending) begin
                    acc = 1'b1;
                end else if (col_dist(int'(last_left), lc) < int'(cfg_tol) &&
                             col_dist(int'(last_right), rc) < int'(cfg_tol)) begin
                    acc = 1'b1;
                end
            end
            if (acc) begin
                last_left     = COL_W'(lc);
                last_right    = COL_W'(rc);
                first_pending = 1'b0;
            end
            res = '{rown, COL_W'(lc), COL_W'(rc), COL_W'(cc), lf, rf, acc};
            got = 1'b1;
            restart_row();
        end
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_word(input logic [PIX_W-1:0] pix, input logic [ROW_W-1:0] rown,
                             input logic fs, input bit typed, input t_lane_res typed_res);
        int        gap;
        bit        got;
        t_lane_res res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({rown, pix});
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_words++;
        track_pixel(pix, rown, fs, got, res);
        if (got) lane_q = {lane_q, (typed ? typed_res : res)};
    endtask

    // lane-shaped row with drifting markings, now and then noise or a broken row
    task automatic send_row(input bit new_frame);
        int               w, ctr, len, k;
        logic [ROW_W-1:0] rown;
        logic [PIX_W-1:0] px [0:MAX_WIDTH-1];
        bit               noisy, broken;
        w      = eff_width();
        ctr    = w / 2;
        rown   = ROW_W'($urandom_range(0, 1023));
        noisy  = $urandom_range(0, 6) == 0;
        broken = $urandom_range(0, 9) == 0;
        if (new_frame) begin
            lpos = $urandom_range(1, ctr);
            rpos = $urandom_range(ctr, w - 1);
        end else begin
            lpos = clamp(lpos + int'($urandom_range(0, 2)) - 1, 1, ctr);
            rpos = clamp(rpos + int'($urandom_range(0, 2)) - 1, ctr, w - 1);
        end
        for (int c = 0; c < w; c++) px[c] = noisy ? PIX_W'($urandom_range(0, 255)) : dark_pixel();
        if (!noisy) begin
            len = $urandom_range(1, 3);
            for (int c = lpos - len + 1; c <= lpos; c++) begin
                if (c >= 1) px[c] = bright_pixel();
            end
            len = $urandom_range(1, 3);
            for (int c = rpos; c < rpos + len && c < w; c++) px[c] = bright_pixel();
            if ($urandom_range(0, 4) == 0) px[$urandom_range(0, w - 1)] = bright_pixel();
        end
        if (broken) begin
            k = $urandom_range(1, w - 1);
            for (int c = 0; c < k; c++) begin
                send_word(PIX_W'($urandom_range(0, 255)), rown, new_frame && c == 0, 1'b0, NO_RES);
            end
            new_frame = 1'b1;
        end
        for (int c = 0; c < w; c++) send_word(px[c], rown, new_frame && c == 0, 1'b0, NO_RES);
    endtask

    task automatic set_regs(input int thr, input int tol, input int wid);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (lane_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data  <= CFG_DATA_W'(tol);
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(wid);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_thr   = THR_W'(thr);
        cfg_tol   = TOL_W'(tol);
        cfg_width = WIDTH_W'(wid);
        n_settings++;
    endtask

    // output side: own stall pattern, plus one long hold-off on request
    initial begin : rx_side
        int cyc;
        int mode;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        cyc           = 0;
        mode          = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 40 == 0) mode = $urandom_range(0, 3);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (cyc % 4) == 0;
                default: m_axis_tready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin : out_check
        t_lane_res seen;
        t_lane_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = '{m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[29:20],
                     m_axis_tdata[39:30], m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2]};
            if (lane_q.size() == 0) begin
                report_mismatch($sformatf("row word for row %0d with none pending",
                                          seen.lane_row));
            end else begin
                want = lane_q.pop_front();
                n_rows++;
                if (want.accepted) n_accepted++;
                if (seen.lane_row != want.lane_row)
                    report_mismatch($sformatf("lane_row got %0d want %0d",
                                              seen.lane_row, want.lane_row));
                if (seen.left_mid != want.left_mid)
                    report_mismatch($sformatf("row %0d left_column got %0d want %0d",
                                              want.lane_row, seen.left_mid, want.left_mid));
                if (seen.right_mid != want.right_mid)
                    report_mismatch($sformatf("row %0d right_column got %0d want %0d",
                                              want.lane_row, seen.right_mid, want.right_mid));
                if (seen.center_col != want.center_col)
                    report_mismatch($sformatf("row %0d center_column got %0d want %0d",
                                              want.lane_row, seen.center_col, want.center_col));
                if (seen.left_found != want.left_found)
                    report_mismatch($sformatf("row %0d left_found got %0d want %0d",
                                              want.lane_row, seen.left_found, want.left_found));
                if (seen.right_found != want.right_found)
                    report_mismatch($sformatf("row %0d right_found got %0d want %0d",
                                              want.lane_row, seen.right_found, want.right_found));
                if (seen.accepted != want.accepted)
                    report_mismatch($sformatf("row %0d accepted got %0d want %0d",
                                              want.lane_row, seen.accepted, want.accepted));
            end
        end
    end

    initial begin : stim
        int phase_base;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_req      = 1'b0;
        burst_left    = 0;
        n_errors      = 0;
        n_words       = 0;
        n_rows        = 0;
        n_accepted    = 0;
        n_settings    = 0;
        cfg_thr       = THR_RESET;
        cfg_tol       = TOL_RESET;
        cfg_width     = WIDTH_RESET;
        first_pending = 1'b1;
        last_left     = '0;
        last_right    = '0;
        restart_row();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // threshold and tolerance keep their reset values, only the width is set
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROW_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(4);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_width = WIDTH_W'(4);

        for (int k = 0; k < DIR_N; k++) begin
            send_word(dir_tab[k].pix, dir_tab[k].row, dir_tab[k].fs,
                      dir_tab[k].typed, dir_tab[k].res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_regs(ph_thr[p], ph_tol[p], ph_wid[p]);
            if (p == PRESSURE_PHASE) hold_req = 1'b1;
            phase_base = n_words;
            send_row(1'b1);
            while (n_words - phase_base < ph_items[p]) send_row($urandom_range(0, 5) == 0);
        end

        s_axis_tvalid <= 1'b0;
        while (lane_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d pixel words and %0d row words over %0d register settings",
                 n_words, n_rows, n_settings + 1);
        $display("%0d rows added a lane point, %0d mismatches", n_accepted, n_errors);
        if (n_errors == 0 && lane_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/lst_pkg.sv
src/lst_front.sv
src/lst_queue.sv
src/lst_back.sv
src/lane_scan_line_tracker.sv
tb/sv/lane_scan_line_tracker_test.sv
